FILE: rtl/core/text_console_scroll_buffer_defines.svh
// assertion macros used by the checker file
`ifndef TEXT_CONSOLE_SCROLL_BUFFER_DEFINES_SVH
`define TEXT_CONSOLE_SCROLL_BUFFER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TCSB_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define TCSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/tcsb_pkg.sv
`timescale 1ns / 1ps

package tcsb_pkg;

  // default geometry
  localparam int ROWS_DEF    = 23;
  localparam int COLUMNS_DEF = 80;

  // character codes
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'h20;

  // request kinds carried in in_tuser
  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // stream widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

endpackage

FILE: rtl/core/tcsb_mem.sv
`timescale 1ns / 1ps

module tcsb_mem #(
  parameter int DEPTH = 1840,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rd_data_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/text_console_scroll_buffer.sv
`timescale 1ns / 1ps
// a read steps ST_READ, ST_DONE; a read outside the screen ST_DONE alone; a plain character
// ST_PUT, ST_DONE; a newline ST_CLEAR, ST_DONE; a wrapping character ST_CLEAR, ST_PUT, ST_DONE.
// one item in flight: the next transaction is taken the cycle after the result is loaded in
// ST_DONE, and a result waits there while out_tready holds back the result before it.
// a newline clears its row one cell per cycle; a scroll moves a top-row offset, no row copies.
// after rst_n the screen memory is filled with spaces, in_tready low.
module text_console_scroll_buffer #(
  parameter int ROWS    = tcsb_pkg::ROWS_DEF,
  parameter int COLUMNS = tcsb_pkg::COLUMNS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // char_code[7:0], read_row[12:8], read_col[19:13], zero pad
  input  logic [tcsb_pkg::IN_TDATA_W-1:0]  in_tdata,
  // req_type[0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // cell_data[7:0], line_index[12:8], column_index[19:13], scrolled[20], zero pad
  output logic [tcsb_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import tcsb_pkg::*;

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CLEAR,
    ST_PUT,
    ST_DONE
  } state_t;

  state_t         state_r;
  logic [AW-1:0]  sweep_r;
  logic [LW-1:0]  line_r;
  logic [LW-1:0]  top_r;
  logic [CW-1:0]  col_r;
  logic [CW-1:0]  clr_col_r;
  logic [7:0]     ch_r;
  logic           pend_char_r;
  logic [7:0]     res_data_r;
  logic           res_scroll_r;
  logic           out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic [7:0]    in_char;
  logic [4:0]    in_row;
  logic [6:0]    in_col;
  logic          in_hs;
  logic          rd_in_range;
  logic [LW-1:0] rd_row_log;
  logic [CW-1:0] rd_col;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] cur_base;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [7:0]    mem_wr_data;
  logic          mem_rd_en;
  logic [7:0]    mem_rd_data;
  logic [31:0]   line_ext;
  logic [31:0]   col_ext;
  logic          out_free;
  logic          out_load;

  // logical row to memory row through the top-row offset
  function automatic logic [LW-1:0] phys_row(input logic [LW-1:0] lrow,
                                             input logic [LW-1:0] trow);
    logic [LW:0] sum;
    sum = {1'b0, lrow} + {1'b0, trow};
    if (sum >= (LW+1)'(ROWS)) begin
      sum = sum - (LW+1)'(ROWS);
    end
    return sum[LW-1:0];
  endfunction

  // input field unpacking
  assign in_char = in_tdata[7:0];
  assign in_row  = in_tdata[12:8];
  assign in_col  = in_tdata[19:13];

  assign in_tready = (state_r == ST_IDLE);
  assign in_hs     = in_tvalid && in_tready;

  // read address of the requested cell
  assign rd_in_range = (32'(in_row) < 32'(ROWS)) && (32'(in_col) < 32'(COLUMNS));
  assign rd_row_log  = LW'(in_row);
  assign rd_col      = CW'(in_col);
  assign rd_addr     = AW'(phys_row(rd_row_log, top_r) * COLUMNS) + AW'(rd_col);

  // base address of the cursor row
  assign cur_base = AW'(phys_row(line_r, top_r) * COLUMNS);

  // memory port control
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = cur_base + AW'(col_r);
    mem_wr_data = SPACE_CODE;
    case (state_r)
      ST_INIT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = sweep_r;
      end
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = cur_base + AW'(clr_col_r);
      end
      ST_PUT: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = ch_r;
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase
  end

  assign mem_rd_en = in_hs && (in_tuser == REQ_READ) && rd_in_range;

  tcsb_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (rd_addr),
    .rd_data (mem_rd_data)
  );

  // cursor fields widened for packing
  assign line_ext = 32'(line_r);
  assign col_ext  = 32'(col_r);
  assign out_free = !out_tvalid_r || out_tready;
  assign out_load = (state_r == ST_DONE) && out_free;

  // request sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      sweep_r      <= '0;
      line_r       <= '0;
      top_r        <= '0;
      col_r        <= '0;
      clr_col_r    <= '0;
      pend_char_r  <= 1'b0;
      res_scroll_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // output valid: set on a loaded result, dropped once taken
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_INIT: begin
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == AW'(DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_hs) begin
            res_data_r   <= '0;
            res_scroll_r <= 1'b0;
            ch_r         <= in_char;
            if (in_tuser == REQ_READ) begin
              state_r <= rd_in_range ? ST_READ : ST_DONE;
            end else if ((in_char == NEWLINE_CODE) || (col_r >= CW'(COLUMNS - 1))) begin
              // new line, scrolling by moving the top row when on the last line
              if (line_r >= LW'(ROWS - 1)) begin
                top_r        <= (top_r == LW'(ROWS - 1)) ? '0 : top_r + 1'b1;
                res_scroll_r <= 1'b1;
              end else begin
                line_r <= line_r + 1'b1;
              end
              col_r       <= '0;
              clr_col_r   <= '0;
              pend_char_r <= (in_char != NEWLINE_CODE);
              state_r     <= ST_CLEAR;
            end else begin
              state_r <= ST_PUT;
            end
          end
        end
        ST_READ: begin
          res_data_r <= mem_rd_data;
          state_r    <= ST_DONE;
        end
        ST_CLEAR: begin
          clr_col_r <= clr_col_r + 1'b1;
          if (clr_col_r == CW'(COLUMNS - 1)) begin
            state_r <= pend_char_r ? ST_PUT : ST_DONE;
          end
        end
        ST_PUT: begin
          col_r   <= col_r + 1'b1;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            out_tdata_r  <= {3'b000, res_scroll_r, col_ext[6:0], line_ext[4:0], res_data_r};
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

FILE: rtl/core/tcsb_checker.sv
`timescale 1ns / 1ps
`include "text_console_scroll_buffer_defines.svh"

module tcsb_checker #(
  parameter int ROWS    = tcsb_pkg::ROWS_DEF,
  parameter int COLUMNS = tcsb_pkg::COLUMNS_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [tcsb_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tcsb_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import tcsb_pkg::*;

  logic [7:0] res_data;
  logic [4:0] res_line;
  logic [6:0] res_col;
  logic       res_scroll;
  logic       in_stall;

  // result fields and input stall
  assign res_data   = out_tdata[7:0];
  assign res_line   = out_tdata[12:8];
  assign res_col    = out_tdata[19:13];
  assign res_scroll = out_tdata[20];
  assign in_stall   = in_tvalid && !in_tready;

  // a stalled result transaction stays put
  `TCSB_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // a waiting input transaction stays put
  `TCSB_ASSERT_NEXT(a_in_hold, in_stall, in_tvalid && $stable(in_tdata) && $stable(in_tuser), "input changed while stalled")

  // cursor stays on the screen
  `TCSB_ASSERT_IMPLY(a_cursor_range, out_tvalid, 32'(res_line) < 32'(ROWS) && 32'(res_col) < 32'(COLUMNS), "cursor beyond screen")

  // a scroll leaves the cursor at column 0, or at column 1 after a wrapped character
  `TCSB_ASSERT_IMPLY(a_scroll_pos, out_tvalid && res_scroll, res_col <= 7'd1, "scroll with cursor mid row")

  // nonzero read data and a scroll never come together
  `TCSB_ASSERT_IMPLY(a_data_scroll, out_tvalid && (res_data != 8'd0), !res_scroll, "read reported a scroll")

endmodule

bind text_console_scroll_buffer tcsb_checker #(
  .ROWS    (ROWS),
  .COLUMNS (COLUMNS)
) u_tcsb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tcsb_pkg::*;

  localparam int ROWS         = ROWS_DEF;
  localparam int COLUMNS      = COLUMNS_DEF;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int DRAIN_CYCLES = COLUMNS + 8;

  typedef struct packed {
    logic [7:0] cell_data;
    logic [4:0] line_index;
    logic [6:0] column_index;
    logic       scrolled;
  } console_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // char_code[7:0], read_row[12:8], read_col[19:13], zero pad
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  // req_type[0]
  logic                   in_tuser   = REQ_PUT;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // cell_data[7:0], line_index[12:8], column_index[19:13], scrolled[20], zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;

  // screen image and cursor as the block should hold them
  logic [7:0] screen_model [ROWS][COLUMNS];
  int         cursor_line;
  int         cursor_col;

  console_result_t expected_results[$];

  bit idle_enable    = 1'b0;
  int out_stall_left = 0;
  int cycle_count    = 0;
  int error_count    = 0;
  int request_count  = 0;
  int put_count      = 0;
  int newline_count  = 0;
  int wrap_count     = 0;
  int scroll_count   = 0;
  int read_count     = 0;
  int oob_read_count = 0;

  text_console_scroll_buffer #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_enable || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // any byte except newline
  function automatic logic [7:0] random_glyph();
    logic [7:0] ch;
    ch = 8'($urandom_range(0, 255));
    while (ch == NEWLINE_CODE) ch = 8'($urandom_range(0, 255));
    return ch;
  endfunction

  task automatic reset_console_model();
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLUMNS; c++) screen_model[r][c] = SPACE_CODE;
    cursor_line = 0;
    cursor_col  = 0;
  endtask

  // next line or scroll, then blank the new current row
  task automatic advance_model_line(output logic did_scroll);
    did_scroll = 1'b0;
    if (cursor_line >= ROWS - 1) begin
      for (int r = 0; r < ROWS - 1; r++)
        for (int c = 0; c < COLUMNS; c++) screen_model[r][c] = screen_model[r + 1][c];
      cursor_line = ROWS - 1;
      did_scroll  = 1'b1;
    end else begin
      cursor_line++;
    end
    cursor_col = 0;
    for (int c = 0; c < COLUMNS; c++) screen_model[cursor_line][c] = SPACE_CODE;
  endtask

  task automatic predict_console_request(input logic req, input logic [7:0] ch,
                                         input logic [4:0] row, input logic [6:0] col);
    console_result_t res;
    res = '0;
    request_count++;
    if (req == REQ_READ) begin
      read_count++;
      if (row < ROWS && col < COLUMNS) res.cell_data = screen_model[row][col];
      else oob_read_count++;
    end else if (ch == NEWLINE_CODE) begin
      put_count++;
      newline_count++;
      advance_model_line(res.scrolled);
    end else begin
      put_count++;
      // a character at the last usable column wraps first
      if (cursor_col >= COLUMNS - 1) begin
        wrap_count++;
        advance_model_line(res.scrolled);
      end
      screen_model[cursor_line][cursor_col] = ch;
      cursor_col++;
    end
    if (res.scrolled) scroll_count++;
    res.line_index   = cursor_line[4:0];
    res.column_index = cursor_col[6:0];
    expected_results.push_back(res);
  endtask

  // one input transaction, with an optional gap before it
  task automatic send_request(input logic req, input logic [7:0] ch,
                              input logic [4:0] row, input logic [6:0] col);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {4'b0, col, row, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_console_request(req, ch, row, col);
  endtask

  task automatic put_char(input logic [7:0] ch);
    send_request(REQ_PUT, ch, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
  endtask

  task automatic read_cell(input int row, input int col);
    send_request(REQ_READ, 8'($urandom_range(0, 255)), row[4:0], col[6:0]);
  endtask

  task automatic check_console_result(input logic [OUT_TDATA_W-1:0] data);
    console_result_t exp_res;
    if (expected_results.size() == 0) begin
      $error("result transaction with no request outstanding: tdata %h", data);
      error_count++;
    end else begin
      exp_res = expected_results.pop_front();
      if (data[7:0] !== exp_res.cell_data) begin
        $error("cell_data: expected %0d, got %0d", exp_res.cell_data, data[7:0]);
        error_count++;
      end
      if (data[12:8] !== exp_res.line_index) begin
        $error("line_index: expected %0d, got %0d", exp_res.line_index, data[12:8]);
        error_count++;
      end
      if (data[19:13] !== exp_res.column_index) begin
        $error("column_index: expected %0d, got %0d", exp_res.column_index, data[19:13]);
        error_count++;
      end
      if (data[20] !== exp_res.scrolled) begin
        $error("scrolled: expected %0d, got %0d", exp_res.scrolled, data[20]);
        error_count++;
      end
    end
  endtask

  // result side: random backpressure and checking
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_stall_left > 0) begin
        out_tready     <= 1'b0;
        out_stall_left <= out_stall_left - 1;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_stall_left <= pick_gap();
      end
      if (out_tvalid && out_tready) check_console_result(out_tdata);
    end
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // blank screen after reset, corners and out of range cells
  task automatic test_reset_screen();
    read_cell(0, 0);
    read_cell(ROWS - 1, COLUMNS - 1);
    read_cell(ROWS - 1, 0);
    read_cell(0, COLUMNS - 1);
    read_cell(ROWS, 0);
    read_cell(0, COLUMNS);
    read_cell(31, 127);
  endtask

  // extreme codes, code zero and a plain newline
  task automatic test_put_extremes();
    put_char(8'h00);
    put_char(8'hFF);
    put_char(8'h41);
    put_char(8'h09);
    put_char(8'h0B);
    read_cell(0, 0);
    read_cell(0, 1);
    read_cell(0, 4);
    put_char(NEWLINE_CODE);
    read_cell(0, 2);
    read_cell(1, 0);
  endtask

  // a full line of text so the last character wraps
  task automatic test_wrap_line();
    int prev_line;
    for (int i = 0; i < COLUMNS; i++) put_char(random_glyph());
    prev_line = (cursor_line > 0) ? cursor_line - 1 : 0;
    read_cell(prev_line, COLUMNS - 2);
    read_cell(prev_line, COLUMNS - 1);
    read_cell(cursor_line, 0);
  endtask

  // run past the last line so every newline there scrolls
  task automatic test_scroll_screen();
    for (int i = 0; i < ROWS + 3; i++) begin
      put_char(random_glyph());
      put_char(NEWLINE_CODE);
    end
    for (int r = 0; r < ROWS; r++) read_cell(r, 0);
  endtask

  // mixed traffic, newline density changes every burst
  task automatic test_random_traffic(input int count, input bit with_idle);
    int nl_pct;
    int r;
    idle_enable = with_idle;
    nl_pct      = 3;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        r = $urandom_range(0, 2);
        nl_pct = (r == 0) ? 25 : (r == 1) ? 3 : 0;
      end
      r = $urandom_range(0, 99);
      if (r < 25) begin
        if ($urandom_range(0, 9) < 8)
          read_cell($urandom_range(0, 1) ? cursor_line : $urandom_range(0, ROWS - 1),
                    $urandom_range(0, COLUMNS - 1));
        else
          read_cell($urandom_range(0, 31), $urandom_range(0, 127));
      end else if ($urandom_range(0, 99) < nl_pct) begin
        put_char(NEWLINE_CODE);
      end else begin
        put_char(random_glyph());
      end
    end
  endtask

  initial begin
    reset_console_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_screen();
    test_put_extremes();
    idle_enable = 1'b1;
    test_wrap_line();
    test_scroll_screen();
    test_random_traffic(300, 1'b0);
    test_random_traffic(1450, 1'b1);

    in_tvalid <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests: %0d puts with %0d newlines, %0d wraps and %0d scrolls",
             request_count, put_count, newline_count, wrap_count, scroll_count);
    $display("%0d cell reads, %0d of them outside the screen", read_count, oob_read_count);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
